// ===== src/abp_pkg.sv =====
// ----------------------------------------------------------------------------
// abp_pkg
// Shared types, format codes and the per-channel blend arithmetic for the
// alpha blend pixel unit.
// ----------------------------------------------------------------------------
package abp_pkg;

	// Destination pixel format codes (code 3 is unused and falls back to xRGB8888)
	typedef enum logic [1:0] {
		FMT_XRGB8888 = 2'd0,
		FMT_RGB565   = 2'd1,
		FMT_RGB555   = 2'd2
	} dest_fmt_t;

	// Configuration register indexes
	localparam int unsigned REG_DEST_FORMAT = 0;

	// APB geometry
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Rounding bias added before the 16-bit drop
	localparam logic signed [27:0] ROUND_BIAS = 28'sd32768;

	// One source pixel request plus the destination it lands on
	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] dest;
	} pix_req_t;

	// One blended result
	typedef struct packed {
		logic        we;
		logic [31:0] pixel;
	} pix_res_t;

	// d + floor((t*257 + 32768) / 65536), t = a*(s-d), kept to 8 bits
	function automatic logic [7:0] mix_chan(input logic [7:0] a, input logic [7:0] s,
			input logic [7:0] d);
		logic signed [9:0]  diff;
		logic signed [18:0] t;
		logic signed [27:0] tx;
		logic signed [27:0] x;
		diff = $signed({2'b00, s}) - $signed({2'b00, d});
		t    = $signed({11'b0, a}) * $signed({{9{diff[9]}}, diff});
		tx   = {{9{t[18]}}, t};
		x    = (tx <<< 8) + tx + ROUND_BIAS;
		// two's complement high bits give the floor of the arithmetic shift
		return d + x[23:16];
	endfunction

endpackage

// ===== src/abp_regs.sv =====
// ----------------------------------------------------------------------------
// abp_regs
// APB register block: holds the destination format register.
// ----------------------------------------------------------------------------
module abp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [abp_pkg::PADDR_W-1:0]  paddr,
	input  logic [abp_pkg::PDATA_W-1:0]  pwdata,
	output logic [abp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output abp_pkg::dest_fmt_t           dest_format
);
	import abp_pkg::*;

	logic [PADDR_W-3:0] reg_idx;
	logic               wr_en;
	dest_fmt_t          fmt_q;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_XRGB8888;
		end else if (wr_en && (reg_idx == (PADDR_W-2)'(REG_DEST_FORMAT))) begin
			fmt_q <= dest_fmt_t'(pwdata[1:0]);
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (reg_idx == (PADDR_W-2)'(REG_DEST_FORMAT)) begin
			prdata = {{(PDATA_W-2){1'b0}}, fmt_q};
		end
	end

	assign dest_format = fmt_q;

endmodule

// ===== src/abp_blend.sv =====
// ----------------------------------------------------------------------------
// abp_blend
// Single-pass blend datapath: unpack destination, mix three channels,
// repack in the destination format.
// ----------------------------------------------------------------------------
module abp_blend (
	input  abp_pkg::dest_fmt_t dest_format,
	input  abp_pkg::pix_req_t  req,
	output abp_pkg::pix_res_t  res
);
	import abp_pkg::*;

	logic [7:0]  dr, dg, db;
	logic [7:0]  rr, rg, rb;
	logic [31:0] packed_pix;

	// unpack destination channels to 8 bits, zero fill
	always_comb begin
		case (dest_format)
			FMT_RGB565: begin
				dr = {req.dest[15:11], 3'b000};
				dg = {req.dest[10:5], 2'b00};
				db = {req.dest[4:0], 3'b000};
			end
			FMT_RGB555: begin
				dr = {req.dest[14:10], 3'b000};
				dg = {req.dest[9:5], 3'b000};
				db = {req.dest[4:0], 3'b000};
			end
			default: begin
				dr = req.dest[23:16];
				dg = req.dest[15:8];
				db = req.dest[7:0];
			end
		endcase
	end

	// opaque source replaces, otherwise blend each channel
	always_comb begin
		if (req.alpha == 8'hff) begin
			rr = req.red;
			rg = req.green;
			rb = req.blue;
		end else begin
			rr = mix_chan(req.alpha, req.red, dr);
			rg = mix_chan(req.alpha, req.green, dg);
			rb = mix_chan(req.alpha, req.blue, db);
		end
	end

	// repack
	always_comb begin
		case (dest_format)
			FMT_RGB565: packed_pix = {16'b0, rr[7:3], rg[7:2], rb[7:3]};
			FMT_RGB555: packed_pix = {17'b0, rr[7:3], rg[7:3], rb[7:3]};
			default:    packed_pix = {8'b0, rr, rg, rb};
		endcase
	end

	// transparent source: no write, zero pixel
	always_comb begin
		if (req.alpha == 8'h00) begin
			res.we    = 1'b0;
			res.pixel = '0;
		end else begin
			res.we    = 1'b1;
			res.pixel = packed_pix;
		end
	end

endmodule

// ===== src/alpha_blend_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_pixel_unit
// Source-over alpha blend of ARGB8888 pixels onto xRGB8888 / RGB565 / RGB555.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  pix     | pix_valid/pix_ready   | fg_alpha, fg_red/green/blue, dest_pixel
//  res     | res_valid/res_ready   | write_enable, pixel_out
//  cfg     | APB psel/penable      | dest_format at byte address 0
//
// Two registers per request: input register, blend logic, result register.
// res_valid rises when the request moves from the input register into the result
// register; throughput is one request per clock while res_ready does not stall,
// set by the single-pass blend between the two registers.
// A stalled result holds in the result register; the input register takes a
// request while empty, else when the result register is empty or drains.
// arst_n clears both valid flags and the format register (xRGB8888).
// ----------------------------------------------------------------------------
module alpha_blend_pixel_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [abp_pkg::PADDR_W-1:0]  paddr,
	input  logic [abp_pkg::PDATA_W-1:0]  pwdata,
	output logic [abp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// pixel requests
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [7:0]                   fg_alpha,
	input  logic [7:0]                   fg_red,
	input  logic [7:0]                   fg_green,
	input  logic [7:0]                   fg_blue,
	input  logic [31:0]                  dest_pixel,
	// results
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         write_enable,
	output logic [31:0]                  pixel_out
);
	import abp_pkg::*;

	dest_fmt_t dest_format;
	pix_req_t  req_s1;
	pix_res_t  res_comb;
	pix_res_t  res_s2;
	logic      vld_s1;
	logic      vld_s2;
	logic      adv_s2;
	logic      adv_s1;

	abp_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.dest_format (dest_format)
	);

	// pipeline flow control
	assign adv_s2    = !vld_s2 || res_ready;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign pix_ready = adv_s1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= pix_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) begin
			req_s1.alpha <= fg_alpha;
			req_s1.red   <= fg_red;
			req_s1.green <= fg_green;
			req_s1.blue  <= fg_blue;
			req_s1.dest  <= dest_pixel;
		end
	end

	abp_blend u_blend (
		.dest_format (dest_format),
		.req         (req_s1),
		.res         (res_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid    = vld_s2;
	assign write_enable = res_s2.we;
	assign pixel_out    = res_s2.pixel;

endmodule

// ===== tb/blend_result_check.sv =====
// ----------------------------------------------------------------------------
// blend_result_check
// Watches the configuration port and the request and result channels of the
// alpha blend pixel unit. It works out each blended pixel as the request is taken,
// queues it, and compares every delivered result with the oldest pending one.
// ----------------------------------------------------------------------------
module blend_result_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [abp_pkg::PADDR_W-1:0]  paddr,
	input  logic [abp_pkg::PDATA_W-1:0]  pwdata,
	input  logic                         pready,
	input  logic                         pix_valid,
	input  logic                         pix_ready,
	input  logic [7:0]                   fg_alpha,
	input  logic [7:0]                   fg_red,
	input  logic [7:0]                   fg_green,
	input  logic [7:0]                   fg_blue,
	input  logic [31:0]                  dest_pixel,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic                         write_enable,
	input  logic [31:0]                  pixel_out,
	output int                           fail_count,
	output int                           outstanding
);
	import abp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0] format_shadow;
	pix_res_t   blended_pixels[$];

	// one channel: d + floor((a*(s-d)*257 + 32768) / 2^16), kept to 8 bits
	function automatic logic [7:0] blend_channel(input int a, input int s, input int d);
		int step;
		step = a * (s - d) * 257 + 32768;
		return 8'((d + (step >>> 16)) & 'hff);
	endfunction

	// whole pixel in the current destination format
	function automatic pix_res_t blend_pixel(input logic [1:0] fmt, input logic [7:0] a,
			input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
			input logic [31:0] dp);
		pix_res_t   res;
		logic [7:0] r, g, b;
		res = '0;
		if (a == 8'd0) begin
			return res;
		end
		// unpack the destination, narrow fields padded with zeros
		case (fmt)
			FMT_RGB565: begin
				r = {dp[15:11], 3'b000};
				g = {dp[10:5], 2'b00};
				b = {dp[4:0], 3'b000};
			end
			FMT_RGB555: begin
				r = {dp[14:10], 3'b000};
				g = {dp[9:5], 3'b000};
				b = {dp[4:0], 3'b000};
			end
			default: begin
				r = dp[23:16];
				g = dp[15:8];
				b = dp[7:0];
			end
		endcase
		if (a == 8'hff) begin
			r = sr;
			g = sg;
			b = sb;
		end else begin
			r = blend_channel(a, sr, r);
			g = blend_channel(a, sg, g);
			b = blend_channel(a, sb, b);
		end
		res.we = 1'b1;
		case (fmt)
			FMT_RGB565: res.pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
			FMT_RGB555: res.pixel = {17'd0, r[7:3], g[7:3], b[7:3]};
			default:    res.pixel = {8'd0, r, g, b};
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		pix_res_t want;
		if (!arst_n) begin
			format_shadow = FMT_XRGB8888;
		end else begin
			// accepted pixel request
			if (pix_valid && pix_ready) begin
				blended_pixels.push_back(blend_pixel(format_shadow, fg_alpha, fg_red,
						fg_green, fg_blue, dest_pixel));
			end
			// delivered result
			if (res_valid && res_ready) begin
				if (blended_pixels.size() == 0) begin
					$error("result with nothing pending: write_enable=%0b pixel_out=%08h",
							write_enable, pixel_out);
					fail_count++;
				end else begin
					want = blended_pixels.pop_front();
					if (write_enable !== want.we) begin
						$error("write_enable: expected %0b, got %0b", want.we, write_enable);
						fail_count++;
					end
					if (pixel_out !== want.pixel) begin
						$error("pixel_out: expected %08h, got %08h", want.pixel, pixel_out);
						fail_count++;
					end
				end
			end
			// format register write, after the requests of this edge
			if (psel && penable && pwrite && pready
					&& paddr == PADDR_W'(4 * REG_DEST_FORMAT)) begin
				format_shadow = pwdata[1:0];
			end
		end
		outstanding = blended_pixels.size();
	end

endmodule

// ===== tb/alpha_blend_pixel_unit_test.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_pixel_unit_test
// Drives the alpha blend pixel unit through every destination format, the
// unused format code included: a few hand-picked pixels per format, then
// random pixels with random gaps and back-pressure, a long result stall and
// a full drain. The blend_result_check instance does the comparing.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_unit_test;
	import abp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FMT_UNUSED   = 2'd3;
	localparam int         RANDOM_PER_PHASE = 96;
	localparam int         NUM_PHASES   = 7;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         HOLD_CYCLES  = 80;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                pix_valid;
	logic                pix_ready;
	logic [7:0]          fg_alpha;
	logic [7:0]          fg_red;
	logic [7:0]          fg_green;
	logic [7:0]          fg_blue;
	logic [31:0]         dest_pixel;
	logic                res_valid;
	logic                res_ready;
	logic                write_enable;
	logic [31:0]         pixel_out;

	int   fail_count;
	int   outstanding;
	int   cycle_count;
	int   hold_seq;
	logic steady;

	alpha_blend_pixel_unit dut (.*);

	blend_result_check check (.*);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("alpha_blend_pixel_unit_test NOT OK");
		$finish;
	end

	// result side: random back-pressure, or a long hold when asked
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	// drop the request valid; n sets the length of the pause
	task automatic pause_pixels(input int n);
		@(negedge clk);
		pix_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// offer one pixel request and wait until it is taken
	task automatic send_pixel(input logic [7:0] a, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [31:0] dp);
		@(negedge clk);
		pix_valid  <= 1'b1;
		fg_alpha   <= a;
		fg_red     <= r;
		fg_green   <= g;
		fg_blue    <= b;
		dest_pixel <= dp;
		do @(posedge clk); while (!pix_ready);
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// random pixel, alpha weighted toward its special values
	task automatic send_random_pixel();
		logic [7:0] a;
		// random gaps of random length before about 7 requests in a hundred
		if (!steady && $urandom_range(99) < 7) begin
			pause_pixels($urandom_range(4, 1));
		end
		case ($urandom_range(9))
			0:       a = 8'h00;
			1:       a = 8'hff;
			2:       a = $urandom_range(1) ? 8'h01 : 8'hfe;
			default: a = 8'($urandom);
		endcase
		send_pixel(a, pick_channel(), pick_channel(), pick_channel(), $urandom);
	endtask

	// format register write once the unit has drained
	task automatic set_format(input logic [1:0] fmt);
		pause_pixels(1);
		wait (outstanding == 0);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_DEST_FORMAT);
		pwdata  <= {30'($urandom), fmt};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hand-picked pixels: alpha extremes, channel extremes, junk in unused bits
	task automatic send_corner_pixels();
		send_pixel(8'h00, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
		send_pixel(8'hff, 8'h80, 8'h00, 8'hff, 32'hdead_beef);
		send_pixel(8'h01, 8'hff, 8'hff, 8'hff, 32'h0000_0000);
		send_pixel(8'hfe, 8'h00, 8'h00, 8'h00, 32'hffff_ffff);
		send_pixel(8'h80, 8'h12, 8'h34, 8'h56, 32'ha5a5_5a5a);
		send_pixel(8'h7f, 8'hff, 8'h00, 8'hff, 32'hff00_ff00);
	endtask

	initial begin
		logic [1:0] phase_fmt[NUM_PHASES];
		phase_fmt = '{FMT_XRGB8888, FMT_RGB565, FMT_RGB555, FMT_UNUSED,
				FMT_RGB555, FMT_RGB565, FMT_XRGB8888};
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_valid    = 1'b0;
		fg_alpha     = '0;
		fg_red       = '0;
		fg_green     = '0;
		fg_blue      = '0;
		dest_pixel   = '0;
		hold_seq     = 0;
		steady       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_format(phase_fmt[p]);
			if (p < 4) begin
				send_corner_pixels();
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// a long stretch with no idling on either side
				if (p == 1) begin
					steady = (i < 60);
				end
				// results held off while requests keep coming
				if (p == 2 && i == 20) begin
					hold_seq++;
				end
				// let everything drain before going on
				if (p == 3 && i == 40) begin
					pause_pixels(1);
					wait (outstanding == 0);
				end
				send_random_pixel();
			end
		end

		pause_pixels(1);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("alpha_blend_pixel_unit_test OK");
		end else begin
			$display("alpha_blend_pixel_unit_test NOT OK");
		end
		$finish;
	end

endmodule

// ===== alpha_blend_pixel_unit.f =====
src/abp_pkg.sv
src/abp_regs.sv
src/abp_blend.sv
src/alpha_blend_pixel_unit.sv
tb/blend_result_check.sv
tb/alpha_blend_pixel_unit_test.sv
